// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the scaler checkers
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is held
`define BIS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off while reset is held
`define BIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bis_pkg.sv -----
// ----------------------------------------------------------------------
// bis_pkg
// shared constants, codes and types of the bilinear image scaler
// ----------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  // frame geometry and fixed point formats
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 16;
  localparam int SCALE_FRAC = 16;
  localparam int CHANNELS   = 3;

  // field widths
  localparam int COORD_W = 12;
  localparam int DIM_W   = 9;
  localparam int SCALE_W = 20;
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = CHANNELS * CHAN_W;

  // derived widths
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int PROD_W = COORD_W + SCALE_W;
  localparam int INT_W  = PROD_W - SCALE_FRAC;
  localparam int EXT_W  = SCALE_FRAC + FRAC_BITS;
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int HSUM_W = CHAN_W + FRAC_BITS;
  localparam int VSUM_W = CHAN_W + 2 * FRAC_BITS;

  // frame banks, split by column and row parity
  localparam int BANKS      = 4;
  localparam int BANK_AW    = XW + YW - 2;
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCALE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE_Y = 2'd3;

  localparam logic [DIM_W-1:0]   RST_DIM   = 9'd256;
  localparam logic [SCALE_W-1:0] RST_SCALE = 20'd65536;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // unit weight
  localparam logic [WGT_W-1:0] ONE_WEIGHT = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [DIM_W-1:0]   src_width;
    logic [DIM_W-1:0]   src_height;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
  } bis_cfg_t;

  // per-stage advance strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } bis_adv_t;

  // frame access request
  typedef struct packed {
    logic                 valid;
    logic                 cmd;
    logic                 ok;
    logic [XW-1:0]        x;
    logic [YW-1:0]        y;
    logic [FRAC_BITS-1:0] dx;
    logic [FRAC_BITS-1:0] dy;
    logic [PIXEL_W-1:0]   pixel;
  } bis_req_t;

  // sideband that travels with the bank read data
  typedef struct packed {
    logic                 valid;
    logic                 blend_en;
    logic                 in_bounds;
    logic                 x_odd;
    logic                 y_odd;
    logic [FRAC_BITS-1:0] dx;
    logic [FRAC_BITS-1:0] dy;
  } bis_tap_t;

  typedef logic [BANKS-1:0][PIXEL_W-1:0] bis_quad_t;

  // limit a configured dimension to the frame store
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (32'(v) > lim) r = DIM_W'(lim);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/bilinear_image_scaler_top.sv -----
// ----------------------------------------------------------------------
// bilinear_image_scaler_top: load a source frame, sample it bilinearly
// pipeline: input, product, frame access, row sums and result registers
// throughput: one beat per cycle unless out_stall holds the pipeline, loads and samples mixed freely; the four
//   parity banks deliver all neighbours in the frame access stage
// reset: pipeline valids cleared, registers back to 256 x 256 at scale 1.0;
//   frame contents are undefined until loaded, no clearing pass
// ----------------------------------------------------------------------
`default_nettype none

module bilinear_image_scaler_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [bis_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [bis_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [bis_pkg::CHAN_W-1:0]       in_blue,
  input  logic [bis_pkg::CHAN_W-1:0]       in_green,
  input  logic [bis_pkg::CHAN_W-1:0]       in_red,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bis_pkg::CHAN_W-1:0]       out_blue,
  output logic [bis_pkg::CHAN_W-1:0]       out_green,
  output logic [bis_pkg::CHAN_W-1:0]       out_red,
  output logic                             out_inside_res,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bis_pkg::bis_cfg_t  cfg_r;
  bis_pkg::bis_adv_t  adv;
  bis_pkg::bis_req_t  req;
  bis_pkg::bis_tap_t  tap;
  bis_pkg::bis_quad_t quad;
  logic               v1;
  logic               v4;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= bis_pkg::RST_DIM;
      cfg_r.src_height <= bis_pkg::RST_DIM;
      cfg_r.scale_x    <= bis_pkg::RST_SCALE;
      cfg_r.scale_y    <= bis_pkg::RST_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bis_pkg::CFG_SOURCE_WIDTH: begin
          cfg_r.src_width <= cfg_data[bis_pkg::DIM_W-1:0];
        end
        bis_pkg::CFG_SOURCE_HEIGHT: begin
          cfg_r.src_height <= cfg_data[bis_pkg::DIM_W-1:0];
        end
        bis_pkg::CFG_INVERSE_SCALE_X: begin
          cfg_r.scale_x <= cfg_data[bis_pkg::SCALE_W-1:0];
        end
        bis_pkg::CFG_INVERSE_SCALE_Y: begin
          cfg_r.scale_y <= cfg_data[bis_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv.s5 = !out_valid || !out_stall;
    adv.s4 = !v4 || adv.s5;
    adv.s3 = !tap.valid || adv.s4;
    adv.s2 = !req.valid || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign in_stall = !adv.s1;

  bis_coord_map u_coord_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_blue    (in_blue),
    .in_green   (in_green),
    .in_red     (in_red),
    .v1         (v1),
    .req        (req)
  );

  bis_frame_mem u_frame_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (req),
    .tap   (tap),
    .quad  (quad)
  );

  bis_blend u_blend (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .tap            (tap),
    .quad           (quad),
    .v4             (v4),
    .out_valid      (out_valid),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_inside_res (out_inside_res)
  );

endmodule

`default_nettype wire

// ----- design/bis_coord_map.sv -----
// ----------------------------------------------------------------------
// bis_coord_map
// input register, coordinate scaling multiply and bounds checks
// ----------------------------------------------------------------------
`default_nettype none

module bis_coord_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bis_pkg::bis_adv_t             adv,
  input  bis_pkg::bis_cfg_t             cfg,
  input  logic                          in_valid,
  input  logic                          in_cmd,
  input  logic [bis_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [bis_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [bis_pkg::CHAN_W-1:0]    in_blue,
  input  logic [bis_pkg::CHAN_W-1:0]    in_green,
  input  logic [bis_pkg::CHAN_W-1:0]    in_red,
  output logic                          v1,
  output bis_pkg::bis_req_t             req
);

  logic                          s1_valid_r;
  logic                          s1_cmd_r;
  logic [bis_pkg::COORD_W-1:0]   s1_x_r;
  logic [bis_pkg::COORD_W-1:0]   s1_y_r;
  logic [bis_pkg::PIXEL_W-1:0]   s1_pix_r;

  logic                          s2_valid_r;
  logic                          s2_cmd_r;
  logic                          s2_load_ok_r;
  logic [bis_pkg::PROD_W-1:0]    s2_prod_x_r;
  logic [bis_pkg::PROD_W-1:0]    s2_prod_y_r;
  logic [bis_pkg::XW-1:0]        s2_lx_r;
  logic [bis_pkg::YW-1:0]        s2_ly_r;
  logic [bis_pkg::PIXEL_W-1:0]   s2_pix_r;

  logic [bis_pkg::DIM_W-1:0]     w_lim;
  logic [bis_pkg::DIM_W-1:0]     h_lim;
  logic [bis_pkg::DIM_W-1:0]     w_m1;
  logic [bis_pkg::DIM_W-1:0]     h_m1;
  logic [bis_pkg::PROD_W-1:0]    prod_x;
  logic [bis_pkg::PROD_W-1:0]    prod_y;
  logic                          load_ok;
  logic [bis_pkg::INT_W-1:0]     int_x;
  logic [bis_pkg::INT_W-1:0]     int_y;
  logic [bis_pkg::EXT_W-1:0]     ext_x;
  logic [bis_pkg::EXT_W-1:0]     ext_y;
  logic                          in_bounds;

  // effective frame size; the user must keep it stable while items are in flight, the block does not enforce it
  assign w_lim = bis_pkg::clamp_dim(cfg.src_width, bis_pkg::MAX_WIDTH);
  assign h_lim = bis_pkg::clamp_dim(cfg.src_height, bis_pkg::MAX_HEIGHT);
  assign w_m1  = (w_lim == '0) ? '0 : w_lim - 1'b1;
  assign h_m1  = (h_lim == '0) ? '0 : h_lim - 1'b1;

  // stage 1: input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv.s1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_cmd_r <= in_cmd;
      s1_x_r   <= in_coord_x;
      s1_y_r   <= in_coord_y;
      s1_pix_r <= {in_red, in_green, in_blue};
    end
  end

  // coordinate times reciprocal scale, load address check
  assign prod_x  = bis_pkg::PROD_W'(s1_x_r) * bis_pkg::PROD_W'(cfg.scale_x);
  assign prod_y  = bis_pkg::PROD_W'(s1_y_r) * bis_pkg::PROD_W'(cfg.scale_y);
  assign load_ok = (s1_x_r < bis_pkg::COORD_W'(w_lim)) &&
                   (s1_y_r < bis_pkg::COORD_W'(h_lim));

  // stage 2: product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv.s2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_cmd_r     <= s1_cmd_r;
      s2_load_ok_r <= load_ok;
      s2_prod_x_r  <= prod_x;
      s2_prod_y_r  <= prod_y;
      s2_lx_r      <= s1_x_r[bis_pkg::XW-1:0];
      s2_ly_r      <= s1_y_r[bis_pkg::YW-1:0];
      s2_pix_r     <= s1_pix_r;
    end
  end

  // split source coordinate into integer and fraction, sample bounds
  assign int_x  = s2_prod_x_r[bis_pkg::PROD_W-1:bis_pkg::SCALE_FRAC];
  assign int_y  = s2_prod_y_r[bis_pkg::PROD_W-1:bis_pkg::SCALE_FRAC];
  assign ext_x  = {s2_prod_x_r[bis_pkg::SCALE_FRAC-1:0], {bis_pkg::FRAC_BITS{1'b0}}};
  assign ext_y  = {s2_prod_y_r[bis_pkg::SCALE_FRAC-1:0], {bis_pkg::FRAC_BITS{1'b0}}};
  assign in_bounds = (int_x < bis_pkg::INT_W'(w_m1)) && (int_y < bis_pkg::INT_W'(h_m1));

  // request towards the frame banks
  always_comb begin
    req.valid = s2_valid_r;
    req.cmd   = s2_cmd_r;
    req.pixel = s2_pix_r;
    req.dx    = ext_x[bis_pkg::EXT_W-1 -: bis_pkg::FRAC_BITS];
    req.dy    = ext_y[bis_pkg::EXT_W-1 -: bis_pkg::FRAC_BITS];
    if (s2_cmd_r == bis_pkg::CMD_LOAD) begin
      req.ok = s2_load_ok_r;
      req.x  = s2_lx_r;
      req.y  = s2_ly_r;
    end else begin
      req.ok = in_bounds;
      req.x  = int_x[bis_pkg::XW-1:0];
      req.y  = int_y[bis_pkg::YW-1:0];
    end
  end

  assign v1 = s1_valid_r;

endmodule

`default_nettype wire

// ----- design/bis_frame_mem.sv -----
// ----------------------------------------------------------------------
// bis_frame_mem
// source frame in four parity banks, one write or four reads a cycle while stage 3 advances
// ----------------------------------------------------------------------
`default_nettype none

module bis_frame_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  bis_pkg::bis_adv_t adv,
  input  bis_pkg::bis_req_t req,
  output bis_pkg::bis_tap_t tap,
  output bis_pkg::bis_quad_t quad
);

  logic                        wr_en;
  logic                        rd_en;
  logic [bis_pkg::XW-1:0]      x_inc;
  logic [bis_pkg::YW-1:0]      y_inc;
  logic                        s3_valid_r;
  logic                        s3_blend_r;
  logic                        s3_inside_r;
  logic                        s3_x_odd_r;
  logic                        s3_y_odd_r;
  logic [bis_pkg::FRAC_BITS-1:0] s3_dx_r;
  logic [bis_pkg::FRAC_BITS-1:0] s3_dy_r;

  assign wr_en = adv.s3 && req.valid && (req.cmd == bis_pkg::CMD_LOAD) && req.ok;
  assign rd_en = adv.s3 && req.valid && (req.cmd == bis_pkg::CMD_SAMPLE);
  assign x_inc = req.x + bis_pkg::XW'(1);
  assign y_inc = req.y + bis_pkg::YW'(1);

  // one bank per column and row parity, neighbours always in distinct banks
  for (genvar b = 0; b < bis_pkg::BANKS; b++) begin : g_bank
    localparam logic COL_ODD = (b % 2) == 1;
    localparam logic ROW_ODD = (b / 2) == 1;

    logic [bis_pkg::PIXEL_W-1:0] bank_mem [bis_pkg::BANK_DEPTH];
    logic [bis_pkg::XW-2:0]      col;
    logic [bis_pkg::YW-2:0]      row;
    logic [bis_pkg::BANK_AW-1:0] addr;
    logic                        sel;
    logic [bis_pkg::PIXEL_W-1:0] rd_r;

    // bank on the item's own parity takes x0, the other takes x0+1
    assign col  = (req.x[0] == COL_ODD) ? req.x[bis_pkg::XW-1:1] : x_inc[bis_pkg::XW-1:1];
    assign row  = (req.y[0] == ROW_ODD) ? req.y[bis_pkg::YW-1:1] : y_inc[bis_pkg::YW-1:1];
    assign addr = {row, col};
    assign sel  = (req.x[0] == COL_ODD) && (req.y[0] == ROW_ODD);

    always_ff @(posedge clk) begin
      if (wr_en && sel) begin
        bank_mem[addr] <= req.pixel;
      end
      if (rd_en) begin
        rd_r <= bank_mem[addr];
      end
    end

    assign quad[b] = rd_r;
  end

  // stage 3 sideband
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv.s3) begin
      s3_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      s3_blend_r  <= (req.cmd == bis_pkg::CMD_SAMPLE) && req.ok;
      s3_inside_r <= req.ok;
      s3_x_odd_r  <= req.x[0];
      s3_y_odd_r  <= req.y[0];
      s3_dx_r     <= req.dx;
      s3_dy_r     <= req.dy;
    end
  end

  always_comb begin
    tap.valid     = s3_valid_r;
    tap.blend_en  = s3_blend_r;
    tap.in_bounds = s3_inside_r;
    tap.x_odd     = s3_x_odd_r;
    tap.y_odd     = s3_y_odd_r;
    tap.dx        = s3_dx_r;
    tap.dy        = s3_dy_r;
  end

endmodule

`default_nettype wire

// ----- design/bis_blend.sv -----
// ----------------------------------------------------------------------
// bis_blend
// horizontal then vertical weighting of the four neighbours, output register
// ----------------------------------------------------------------------
`default_nettype none

module bis_blend (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bis_pkg::bis_adv_t           adv,
  input  bis_pkg::bis_tap_t           tap,
  input  bis_pkg::bis_quad_t          quad,
  output logic                        v4,
  output logic                        out_valid,
  output logic [bis_pkg::CHAN_W-1:0]  out_blue,
  output logic [bis_pkg::CHAN_W-1:0]  out_green,
  output logic [bis_pkg::CHAN_W-1:0]  out_red,
  output logic                        out_inside_res
);

  logic [1:0]                      i_tl;
  logic [1:0]                      i_tr;
  logic [1:0]                      i_bl;
  logic [1:0]                      i_br;
  logic [bis_pkg::PIXEL_W-1:0]     p_tl;
  logic [bis_pkg::PIXEL_W-1:0]     p_tr;
  logic [bis_pkg::PIXEL_W-1:0]     p_bl;
  logic [bis_pkg::PIXEL_W-1:0]     p_br;
  logic [bis_pkg::WGT_W-1:0]       wx0;
  logic [bis_pkg::WGT_W-1:0]       wx1;
  logic [bis_pkg::HSUM_W-1:0]      top_c [bis_pkg::CHANNELS];
  logic [bis_pkg::HSUM_W-1:0]      bot_c [bis_pkg::CHANNELS];

  logic                            s4_valid_r;
  logic                            s4_blend_r;
  logic                            s4_inside_r;
  logic [bis_pkg::FRAC_BITS-1:0]   s4_dy_r;
  logic [bis_pkg::HSUM_W-1:0]      s4_top_r [bis_pkg::CHANNELS];
  logic [bis_pkg::HSUM_W-1:0]      s4_bot_r [bis_pkg::CHANNELS];

  logic [bis_pkg::WGT_W-1:0]       wy0;
  logic [bis_pkg::WGT_W-1:0]       wy1;
  logic [bis_pkg::VSUM_W-1:0]      vsum_c [bis_pkg::CHANNELS];
  logic [bis_pkg::PIXEL_W-1:0]     pix_nxt;

  logic                            out_valid_r;
  logic                            out_inside_r;
  logic [bis_pkg::PIXEL_W-1:0]     out_pix_r;

  // route the banks to the four neighbour positions
  assign i_tl = {tap.y_odd, tap.x_odd};
  assign i_tr = {tap.y_odd, ~tap.x_odd};
  assign i_bl = {~tap.y_odd, tap.x_odd};
  assign i_br = {~tap.y_odd, ~tap.x_odd};
  assign p_tl = quad[i_tl];
  assign p_tr = quad[i_tr];
  assign p_bl = quad[i_bl];
  assign p_br = quad[i_br];

  // horizontal weights
  assign wx1 = {1'b0, tap.dx};
  assign wx0 = bis_pkg::ONE_WEIGHT - wx1;

  // horizontal blend, one pair of products per channel and row
  always_comb begin
    for (int c = 0; c < bis_pkg::CHANNELS; c++) begin
      top_c[c] = bis_pkg::HSUM_W'(p_tl[c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W])
                   * bis_pkg::HSUM_W'(wx0)
               + bis_pkg::HSUM_W'(p_tr[c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W])
                   * bis_pkg::HSUM_W'(wx1);
      bot_c[c] = bis_pkg::HSUM_W'(p_bl[c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W])
                   * bis_pkg::HSUM_W'(wx0)
               + bis_pkg::HSUM_W'(p_br[c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W])
                   * bis_pkg::HSUM_W'(wx1);
    end
  end

  // stage 4: row sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv.s4) begin
      s4_valid_r <= tap.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      s4_blend_r  <= tap.blend_en;
      s4_inside_r <= tap.in_bounds;
      s4_dy_r     <= tap.dy;
      for (int c = 0; c < bis_pkg::CHANNELS; c++) begin
        s4_top_r[c] <= top_c[c];
        s4_bot_r[c] <= bot_c[c];
      end
    end
  end

  // vertical blend and truncation of the double fraction
  assign wy1 = {1'b0, s4_dy_r};
  assign wy0 = bis_pkg::ONE_WEIGHT - wy1;

  always_comb begin
    for (int c = 0; c < bis_pkg::CHANNELS; c++) begin
      vsum_c[c] = bis_pkg::VSUM_W'(s4_top_r[c]) * bis_pkg::VSUM_W'(wy0)
                + bis_pkg::VSUM_W'(s4_bot_r[c]) * bis_pkg::VSUM_W'(wy1);
      pix_nxt[c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W] =
        s4_blend_r ? vsum_c[c][bis_pkg::VSUM_W-1 -: bis_pkg::CHAN_W] : '0;
    end
  end

  // stage 5: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv.s5) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      out_pix_r    <= pix_nxt;
      out_inside_r <= s4_inside_r;
    end
  end

  assign v4             = s4_valid_r;
  assign out_valid      = out_valid_r;
  assign out_blue       = out_pix_r[0*bis_pkg::CHAN_W +: bis_pkg::CHAN_W];
  assign out_green      = out_pix_r[1*bis_pkg::CHAN_W +: bis_pkg::CHAN_W];
  assign out_red        = out_pix_r[2*bis_pkg::CHAN_W +: bis_pkg::CHAN_W];
  assign out_inside_res = out_inside_r;

endmodule

`default_nettype wire

// ----- design/bis_checker.sv -----
// ----------------------------------------------------------------------
// bis_checker
// port-level checks on the scaler, bound to the top level
// ----------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module bis_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bis_pkg::CHAN_W-1:0]  out_blue,
  input logic [bis_pkg::CHAN_W-1:0]  out_green,
  input logic [bis_pkg::CHAN_W-1:0]  out_red,
  input logic                        out_inside_res
);

  // a stalled result beat stays and holds its payload
  `BIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_blue) && $stable(out_green) && $stable(out_red) && $stable(out_inside_res), "stalled result beat changed")

  // outside samples and loads carry zero channels
  `BIS_ASSERT_IMPLY(a_zero_outside, clk, rst_n, out_valid && !out_inside_res, (out_blue == '0) && (out_green == '0) && (out_red == '0), "outside result has nonzero channel")

  // with no result waiting the pipeline always takes a beat
  `BIS_ASSERT_IMPLY(a_empty_takes, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")

  // nothing leaves the pipeline right after reset
  `BIS_ASSERT_IMPLY(a_reset_empty, clk, rst_n, $past(!rst_n), !out_valid, "result beat straight after reset")

endmodule

bind bilinear_image_scaler_top bis_checker u_bis_checker (.*);

`default_nettype wire

// ----- dv/bis_result_checker.sv -----
// ----------------------------------------------------------------------
// bis_result_checker
// watches the configuration, input and result channels of the scaler,
// keeps its own copy of the registers and the source frame, predicts the
// result of every accepted input beat and compares each accepted result
// beat field by field with the oldest prediction still waiting
// ----------------------------------------------------------------------

module bis_result_checker
  import bis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  input  logic [CHAN_W-1:0]     in_blue,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CHAN_W-1:0]     out_blue,
  input  logic [CHAN_W-1:0]     out_green,
  input  logic [CHAN_W-1:0]     out_red,
  input  logic                  out_inside_res,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              in_bounds;
  } scaled_px_t;

  // register copy, as seen on the configuration channel
  logic [DIM_W-1:0]   cfg_w  = RST_DIM;
  logic [DIM_W-1:0]   cfg_h  = RST_DIM;
  logic [SCALE_W-1:0] cfg_sx = RST_SCALE;
  logic [SCALE_W-1:0] cfg_sy = RST_SCALE;

  // source frame copy, row-major, blue in the low byte
  logic [PIXEL_W-1:0] frame_px [0:MAX_WIDTH*MAX_HEIGHT-1];

  scaled_px_t awaited_px[$];
  int         mismatches = 0;
  int         awaiting   = 0;

  assign fail_count = mismatches;
  assign pending    = awaiting;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // store a pixel on load, blend the four neighbours on sample
  function automatic scaled_px_t blend_or_store(input logic cmd,
                                                input logic [COORD_W-1:0] cx,
                                                input logic [COORD_W-1:0] cy,
                                                input logic [PIXEL_W-1:0] px);
    scaled_px_t         res;
    int unsigned        w, h, x0, y0, c;
    logic [63:0]        one, sx, sy, lim_x, lim_y, dx, dy, top_v, bot_v, acc;
    logic [PIXEL_W-1:0] p00, p10, p01, p11;
    res = '0;
    w = (cfg_w > MAX_WIDTH) ? MAX_WIDTH : cfg_w;
    h = (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h;
    if (cmd == CMD_LOAD) begin
      if (cx < w && cy < h) begin
        frame_px[cy * MAX_WIDTH + cx] = px;
        res.in_bounds = 1'b1;
      end
      return res;
    end
    // map into the source frame, fraction re-expressed at weight precision
    one = 64'd1 << FRAC_BITS;
    sx = ((64'(cx) * 64'(cfg_sx)) << FRAC_BITS) >> SCALE_FRAC;
    sy = ((64'(cy) * 64'(cfg_sy)) << FRAC_BITS) >> SCALE_FRAC;
    lim_x = 64'(w > 0 ? w - 1 : 0) << FRAC_BITS;
    lim_y = 64'(h > 0 ? h - 1 : 0) << FRAC_BITS;
    if (!(sx < lim_x && sy < lim_y)) return res;
    x0 = 32'(sx >> FRAC_BITS);
    y0 = 32'(sy >> FRAC_BITS);
    dx = sx & (one - 1);
    dy = sy & (one - 1);
    p00 = frame_px[y0 * MAX_WIDTH + x0];
    p10 = frame_px[y0 * MAX_WIDTH + x0 + 1];
    p01 = frame_px[(y0 + 1) * MAX_WIDTH + x0];
    p11 = frame_px[(y0 + 1) * MAX_WIDTH + x0 + 1];
    // exact sums, one truncation at the end
    for (c = 0; c < CHANNELS; c++) begin
      top_v = 64'(p00[c*CHAN_W +: CHAN_W]) * (one - dx) + 64'(p10[c*CHAN_W +: CHAN_W]) * dx;
      bot_v = 64'(p01[c*CHAN_W +: CHAN_W]) * (one - dx) + 64'(p11[c*CHAN_W +: CHAN_W]) * dx;
      acc = (top_v * (one - dy) + bot_v * dy) >> (2 * FRAC_BITS);
      case (c)
        0: res.blue = acc[CHAN_W-1:0];
        1: res.green = acc[CHAN_W-1:0];
        default: res.red = acc[CHAN_W-1:0];
      endcase
    end
    res.in_bounds = 1'b1;
    return res;
  endfunction

  // channel monitor: register writes, input beats, result beats
  always @(posedge clk) begin : watch_channels
    scaled_px_t want;
    if (!rst_n) begin
      cfg_w  = RST_DIM;
      cfg_h  = RST_DIM;
      cfg_sx = RST_SCALE;
      cfg_sy = RST_SCALE;
      awaited_px.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SOURCE_WIDTH:    cfg_w  = cfg_data[DIM_W-1:0];
          CFG_SOURCE_HEIGHT:   cfg_h  = cfg_data[DIM_W-1:0];
          CFG_INVERSE_SCALE_X: cfg_sx = cfg_data[SCALE_W-1:0];
          CFG_INVERSE_SCALE_Y: cfg_sy = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaited_px.push_back(blend_or_store(in_cmd, in_coord_x, in_coord_y,
                                            {in_red, in_green, in_blue}));
      if (out_valid && !out_stall) begin
        if (awaited_px.size() == 0) begin
          report_mismatch("result beat with no result expected");
        end else begin
          want = awaited_px.pop_front();
          if (out_blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", out_blue, want.blue));
          if (out_green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", out_green, want.green));
          if (out_red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", out_red, want.red));
          if (out_inside_res !== want.in_bounds)
            report_mismatch($sformatf("inside got %0b want %0b", out_inside_res,
                                      want.in_bounds));
        end
      end
    end
    awaiting <= awaited_px.size();
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------
// testbench
// drives the bilinear image scaler with a directed opening and then
// random phases at several frame sizes and scale factors, loading the
// part of the frame that samples aim at before sampling it; both sides
// idle at random and a checker beside the block predicts every result
// ----------------------------------------------------------------------

module testbench;
  import bis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PER_PHASE = 48;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic                  in_cmd         = CMD_LOAD;
  logic [COORD_W-1:0]    in_coord_x     = '0;
  logic [COORD_W-1:0]    in_coord_y     = '0;
  logic [CHAN_W-1:0]     in_blue        = '0;
  logic [CHAN_W-1:0]     in_green       = '0;
  logic [CHAN_W-1:0]     in_red         = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [CHAN_W-1:0]     out_blue;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_red;
  logic                  out_inside_res;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_SOURCE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  int                    fail_count;
  int                    pending;

  // register values as last written, for stimulus shaping
  logic [DIM_W-1:0]   cur_w  = RST_DIM;
  logic [DIM_W-1:0]   cur_h  = RST_DIM;
  logic [SCALE_W-1:0] cur_sx = RST_SCALE;
  logic [SCALE_W-1:0] cur_sy = RST_SCALE;

  // pixels written so far, so that no sample reads an unwritten one
  bit pix_loaded [0:MAX_WIDTH*MAX_HEIGHT-1];

  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;

  bilinear_image_scaler_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_inside_res (out_inside_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  bis_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_inside_res (out_inside_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #10 clk = ~clk;

  // result side: after each accepted beat, stall for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (out_valid && !out_stall) begin
      stall_draw = rx_quiet ? 0 : $urandom_range(0, 11);
      if (stall_draw != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_draw;
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned frame_span(input logic [DIM_W-1:0] v, input int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // true if the sample falls outside or all four neighbours were written
  function automatic bit sample_safe(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    int unsigned w, h, x0, y0;
    logic [63:0] sx, sy;
    w = frame_span(cur_w, MAX_WIDTH);
    h = frame_span(cur_h, MAX_HEIGHT);
    sx = 64'(cx) * 64'(cur_sx);
    sy = 64'(cy) * 64'(cur_sy);
    if (sx >= (64'(w > 0 ? w - 1 : 0) << SCALE_FRAC)) return 1'b1;
    if (sy >= (64'(h > 0 ? h - 1 : 0) << SCALE_FRAC)) return 1'b1;
    x0 = 32'(sx >> SCALE_FRAC);
    y0 = 32'(sy >> SCALE_FRAC);
    return pix_loaded[y0 * MAX_WIDTH + x0] && pix_loaded[y0 * MAX_WIDTH + x0 + 1] &&
           pix_loaded[(y0 + 1) * MAX_WIDTH + x0] && pix_loaded[(y0 + 1) * MAX_WIDTH + x0 + 1];
  endfunction

  // destination coordinate that lands near a given source pixel
  function automatic logic [COORD_W-1:0] aim_coord(input int unsigned target,
                                                   input logic [SCALE_W-1:0] scale);
    longint unsigned t;
    if (scale == '0) return COORD_W'($urandom);
    t = target;
    t = ((t << SCALE_FRAC) + $urandom_range(0, 65535)) / scale;
    if (t > 4095) t = 4095;
    return COORD_W'(t);
  endfunction

  // one input beat, after a drawn idle gap
  task automatic drive_cmd(input logic cmd, input logic [COORD_W-1:0] cx,
                           input logic [COORD_W-1:0] cy, input logic [CHAN_W-1:0] b,
                           input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] r);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_coord_x <= cx;
    in_coord_y <= cy;
    in_blue    <= b;
    in_green   <= g;
    in_red     <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_pixel(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] r);
    if (cx < frame_span(cur_w, MAX_WIDTH) && cy < frame_span(cur_h, MAX_HEIGHT))
      pix_loaded[cy * MAX_WIDTH + cx] = 1'b1;
    drive_cmd(CMD_LOAD, cx, cy, b, g, r);
  endtask

  task automatic load_random(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    load_pixel(cx, cy, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
  endtask

  // colour fields carry noise on a sample, the block ignores them
  task automatic sample_at(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    drive_cmd(CMD_SAMPLE, cx, cy, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
  endtask

  // drop valid and hold off until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // registers change only with the pipeline empty
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_data,
                              input logic [CFG_DATA_W-1:0] h_data,
                              input logic [CFG_DATA_W-1:0] sx_data,
                              input logic [CFG_DATA_W-1:0] sy_data);
    wait_drained();
    repeat (6) @(posedge clk);
    write_reg(CFG_SOURCE_WIDTH, w_data);
    write_reg(CFG_SOURCE_HEIGHT, h_data);
    write_reg(CFG_INVERSE_SCALE_X, sx_data);
    write_reg(CFG_INVERSE_SCALE_Y, sy_data);
    cfg_valid <= 1'b0;
    cur_w  = w_data[DIM_W-1:0];
    cur_h  = h_data[DIM_W-1:0];
    cur_sx = sx_data[SCALE_W-1:0];
    cur_sy = sy_data[SCALE_W-1:0];
  endtask

  // one setting: fill the aimed-at box, then a random mix of beats
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data,
                           input logic [CFG_DATA_W-1:0] sx_data,
                           input logic [CFG_DATA_W-1:0] sy_data,
                           input int unsigned bw, input int unsigned bh);
    int unsigned        xi, yi, i, roll, tries, hold_at, span_w;
    logic [COORD_W-1:0] cx, cy;
    bit                 placed;
    set_geometry(w_data, h_data, sx_data, sy_data);
    span_w  = frame_span(cur_w, MAX_WIDTH);
    hold_at = $urandom_range(5, RAND_PER_PHASE - 5);
    for (yi = 0; yi < bh; yi++)
      for (xi = 0; xi < bw; xi++)
        if (!pix_loaded[yi * MAX_WIDTH + xi]) load_random(COORD_W'(xi), COORD_W'(yi));
    for (i = 0; i < RAND_PER_PHASE; i++) begin
      if (i == hold_at) wait_drained();
      if (i % 16 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // overwrite a pixel inside the box
        load_random(COORD_W'($urandom_range(0, bw > 0 ? bw - 1 : 0)),
                    COORD_W'($urandom_range(0, bh > 0 ? bh - 1 : 0)));
      end else if (roll < 20) begin
        load_random(COORD_W'($urandom), COORD_W'($urandom));
      end else if (roll < 25) begin
        // loads around the right and bottom edges
        load_random(COORD_W'($urandom_range(0, span_w + 1)),
                    COORD_W'($urandom_range(0, frame_span(cur_h, MAX_HEIGHT) + 1)));
      end else begin
        placed = 1'b0;
        for (tries = 0; tries < 8 && !placed; tries++) begin
          if (roll < 35) begin
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
          end else begin
            cx = aim_coord($urandom_range(0, bw), cur_sx);
            cy = aim_coord($urandom_range(0, bh), cur_sy);
          end
          placed = sample_safe(cx, cy);
        end
        if (placed) sample_at(cx, cy);
        else load_random('1, '1);
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    int unsigned wv, hv;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corner pixels at reset geometry, scale 1.0
    load_pixel(12'd0, 12'd0, 8'hff, 8'h00, 8'h80);
    load_pixel(12'd1, 12'd0, 8'h00, 8'hff, 8'h7f);
    load_pixel(12'd0, 12'd1, 8'h55, 8'haa, 8'h01);
    load_pixel(12'd1, 12'd1, 8'haa, 8'h55, 8'hfe);
    load_pixel(12'd254, 12'd254, 8'hff, 8'hff, 8'hff);
    load_pixel(12'd255, 12'd254, 8'h00, 8'h00, 8'h00);
    load_pixel(12'd254, 12'd255, 8'h0f, 8'hf0, 8'h3c);
    load_pixel(12'd255, 12'd255, 8'hff, 8'h00, 8'hff);
    // loads beyond the frame are dropped
    load_pixel(12'd256, 12'd0, 8'hff, 8'hff, 8'hff);
    load_pixel(12'd0, 12'd256, 8'hff, 8'hff, 8'hff);
    load_pixel(12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff);
    // whole-pixel samples, inside and on or past the last row and column
    sample_at(12'd0, 12'd0);
    sample_at(12'd254, 12'd254);
    sample_at(12'd255, 12'd0);
    sample_at(12'd0, 12'd255);
    sample_at(12'hfff, 12'hfff);
    // half scale: midway blends of the corners
    set_geometry(20'd256, 20'd256, 20'd32768, 20'd32768);
    sample_at(12'd1, 12'd1);
    sample_at(12'd509, 12'd509);
    sample_at(12'd509, 12'd508);
    sample_at(12'd510, 12'd3);
    sample_at(12'd3, 12'd510);

    // random phases over sizes and scales, extremes among them
    run_phase(20'd8, 20'd6, 20'd49152, 20'd81920, 8, 6);
    run_phase(20'd2, 20'd2, 20'd1, 20'hfffff, 2, 2);
    run_phase(20'd256, 20'd2, 20'($urandom_range(1, 20'hfffff)),
              20'($urandom_range(4096, 200000)), 24, 2);
    run_phase(20'd2, 20'd256, 20'($urandom_range(4096, 200000)),
              20'($urandom_range(1, 20'hfffff)), 2, 24);
    run_phase(20'd511, 20'd300, 20'd0, 20'($urandom_range(1, 150000)), 4, 4);
    run_phase(20'd0, 20'd1, 20'($urandom_range(1, 20'hfffff)),
              20'($urandom_range(1, 20'hfffff)), 0, 0);
    run_phase(20'd1, 20'd5, 20'($urandom_range(1, 20'hfffff)),
              20'($urandom_range(1, 20'hfffff)), 0, 0);
    run_phase(20'd12, 20'd10, 20'($urandom_range(1, 20'hfffff)),
              20'($urandom_range(1, 20'hfffff)), 12, 10);
    wv = $urandom_range(2, 16);
    hv = $urandom_range(2, 16);
    // junk above the dimension fields
    run_phase({11'($urandom), 9'(wv)}, {11'($urandom), 9'(hv)},
              20'($urandom_range(1, 20'hfffff)), 20'($urandom_range(1, 20'hfffff)), wv, hv);

    wait_drained();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
